// ----- design/jhp_pkg.sv -----
package jhp_pkg;

	localparam int TEMP_W      = 24;
	localparam int SUM_W       = TEMP_W + 2;
	localparam int COORD_IN_W  = 5;
	localparam int COUNT_W     = 16;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 24;

	// Operation codes of an input item
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_SWEEP = 2'd1;
	localparam logic [1:0] MODE_RUN   = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LIMIT     = 1'd1;

	localparam logic [TEMP_W-1:0]  THRESHOLD_RESET = 24'd6619;
	localparam logic [COUNT_W-1:0] LIMIT_RESET     = 16'hFFFF;
	localparam logic [TEMP_W-1:0]  HOT_VALUE       = 24'h640000;

	// Stencil unit operations
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_ADD  = 2'd2;
	localparam logic [1:0] OP_EVAL = 2'd3;

	typedef struct packed {
		logic [1:0]            mode;
		logic [COORD_IN_W-1:0] row;
		logic [COORD_IN_W-1:0] column;
		logic [TEMP_W-1:0]     write_temperature;
	} item_t;

	typedef struct packed {
		logic [TEMP_W-1:0]  read_temperature;
		logic               is_stable;
		logic [COUNT_W-1:0] sweeps_done;
	} result_t;

	typedef struct packed {
		logic [1:0] op;
		logic       border;
		logic       last;
	} stencil_ctrl_t;

endpackage

// ----- design/jhp_grid_ram.sv -----
module jhp_grid_ram #(
	parameter int DATA_W = 24,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr0,
	input  logic [ADDR_W-1:0] raddr1,
	output logic [DATA_W-1:0] rdata0,
	output logic [DATA_W-1:0] rdata1
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// ----- design/jhp_stencil_unit.sv -----
module jhp_stencil_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  jhp_pkg::stencil_ctrl_t       ctrl,
	input  logic [jhp_pkg::TEMP_W-1:0]   rdata0,
	input  logic [jhp_pkg::TEMP_W-1:0]   rdata1,
	input  logic [jhp_pkg::TEMP_W-1:0]   threshold,
	output logic [jhp_pkg::TEMP_W-1:0]   new_value,
	output logic                         sweep_stable
);
	import jhp_pkg::*;

	logic [SUM_W-1:0]        acc_q;
	logic                    unstable_q;
	logic signed [SUM_W-1:0] diff;
	logic                    cell_unstable;

	// In the evaluate step rdata0 carries the old center value
	assign new_value     = ctrl.border ? rdata0 : acc_q[SUM_W-1:2];
	assign diff          = $signed({2'b00, new_value}) - $signed({2'b00, rdata0});
	assign cell_unstable = !(diff < $signed({2'b00, threshold}));
	assign sweep_stable  = !(unstable_q || cell_unstable);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: acc_q <= SUM_W'(rdata0) + SUM_W'(rdata1);
			OP_ADD:  acc_q <= acc_q + SUM_W'(rdata0) + SUM_W'(rdata1);
			default: acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unstable_q <= 1'b0;
		end else if (ctrl.op == OP_EVAL) begin
			unstable_q <= ctrl.last ? 1'b0 : (unstable_q || cell_unstable);
		end
	end

endmodule

// ----- design/jacobi_heat_plate_relaxation.sv -----
// Throughput: one item at a time; a sweep steps each cell through the states S_LR, S_CTR
// and S_WB on the grid memory's two read ports, with one adder shared over the stencil.
// Reset: async active low; a fill pass then writes the start pattern into both grid banks,
// and no item transfers until it ends.
module jacobi_heat_plate_relaxation #(
	parameter int GRID_SIZE = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  jhp_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output jhp_pkg::result_t                 result,
	input  logic                             cfg_write,
	input  logic [jhp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [jhp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import jhp_pkg::*;

	localparam int CW = $clog2(GRID_SIZE);
	localparam int AW = 2 * CW;
	localparam logic [CW-1:0] LAST_IDX = CW'(GRID_SIZE - 1);

	// Sequencer states
	localparam logic [2:0] S_INIT = 3'd0;  // fill pass after reset
	localparam logic [2:0] S_IDLE = 3'd1;  // wait for an item
	localparam logic [2:0] S_READ = 3'd2;  // read data returns
	localparam logic [2:0] S_UD   = 3'd3;  // issue up and down of first cell
	localparam logic [2:0] S_LR   = 3'd4;  // issue left and right, load up + down
	localparam logic [2:0] S_CTR  = 3'd5;  // issue center, add left + right
	localparam logic [2:0] S_WB   = 3'd6;  // evaluate, write back, issue next up and down

	// Neighbor selectors
	localparam logic [1:0] NB_UP    = 2'd0;
	localparam logic [1:0] NB_DOWN  = 2'd1;
	localparam logic [1:0] NB_LEFT  = 2'd2;
	localparam logic [1:0] NB_RIGHT = 2'd3;

	function automatic logic on_border(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return (r == '0) || (c == '0) || (r == LAST_IDX) || (c == LAST_IDX);
	endfunction

	// Border cells read their own address in every slot; the result is dropped anyway
	function automatic logic [AW-1:0] nbr_addr(input logic [CW-1:0] r,
			input logic [CW-1:0] c, input logic [1:0] dir);
		logic [AW-1:0] a;
		a = {r, c};
		if (!on_border(r, c)) begin
			case (dir)
				NB_UP:    a = {r - CW'(1), c};
				NB_DOWN:  a = {r + CW'(1), c};
				NB_LEFT:  a = {r, c - CW'(1)};
				NB_RIGHT: a = {r, c + CW'(1)};
				default:  a = {r, c};
			endcase
		end
		return a;
	endfunction

	logic [2:0]          state_q;
	logic [CW-1:0]       row_q, col_q;
	logic [CW-1:0]       row_nxt, col_nxt;
	logic                cell_last;
	logic                cur_q;             // bank holding the current grid
	logic                stable_q;
	logic [1:0]          mode_q;
	logic                inside_q;
	logic [COUNT_W-1:0]  done_q;
	logic [TEMP_W-1:0]   threshold_q;
	logic [COUNT_W-1:0]  limit_q;
	logic [COUNT_W-1:0]  limit_eff;
	logic                res_valid_q;
	result_t             res_q;

	logic                accept;
	logic                item_inside;
	logic [CW-1:0]       item_row, item_col;
	logic [AW-1:0]       raddr0, raddr1, waddr;
	logic [TEMP_W-1:0]   wdata;
	logic                wr_cur, wr_dest, wr_both;
	logic                we_a, we_b;
	logic [TEMP_W-1:0]   rd0_a, rd1_a, rd0_b, rd1_b, rd0, rd1;
	logic [TEMP_W-1:0]   init_value;
	logic [TEMP_W-1:0]   new_value;
	logic                sweep_stable;
	logic                run_on;
	logic                res_load;
	stencil_ctrl_t       sctrl;

	// Hold off new items while busy or while the result register cannot drain
	assign item_stall   = (state_q != S_IDLE) || (res_valid_q && result_stall);
	assign accept       = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign item_inside = (32'(item.row) < 32'(GRID_SIZE)) && (32'(item.column) < 32'(GRID_SIZE));
	assign item_row    = CW'(item.row);
	assign item_col    = CW'(item.column);

	// Raster cursor advance
	always_comb begin
		cell_last = (row_q == LAST_IDX) && (col_q == LAST_IDX);
		if (col_q == LAST_IDX) begin
			col_nxt = '0;
			row_nxt = cell_last ? '0 : row_q + CW'(1);
		end else begin
			col_nxt = col_q + CW'(1);
			row_nxt = row_q;
		end
	end

	assign init_value = (col_q != '0 && col_q != LAST_IDX && (row_q == '0 || row_q == LAST_IDX))
		? HOT_VALUE : '0;

	assign limit_eff = (limit_q == '0) ? COUNT_W'(1) : limit_q;
	// Keep sweeping in run mode while unstable and under the limit
	assign run_on = (mode_q == MODE_RUN) && !sweep_stable &&
		((17'(done_q) + 17'd1) < 17'(limit_eff));

	// Load the result register when an item finishes
	assign res_load = (state_q == S_IDLE && accept && item.mode == MODE_WRITE)
		|| (state_q == S_READ) || (state_q == S_WB && cell_last && !run_on);

	// Read address selection for the two shared ports
	always_comb begin
		raddr0 = {row_q, col_q};
		raddr1 = {row_q, col_q};
		case (state_q)
			S_IDLE: begin
				raddr0 = {item_row, item_col};
			end
			S_UD: begin
				raddr0 = nbr_addr(row_q, col_q, NB_UP);
				raddr1 = nbr_addr(row_q, col_q, NB_DOWN);
			end
			S_LR: begin
				raddr0 = nbr_addr(row_q, col_q, NB_LEFT);
				raddr1 = nbr_addr(row_q, col_q, NB_RIGHT);
			end
			S_WB: begin
				raddr0 = nbr_addr(row_nxt, col_nxt, NB_UP);
				raddr1 = nbr_addr(row_nxt, col_nxt, NB_DOWN);
			end
			default: begin
				raddr0 = {row_q, col_q};
				raddr1 = {row_q, col_q};
			end
		endcase
	end

	// Write side: fill pass hits both banks, a cell write the current bank,
	// a sweep the other bank
	always_comb begin
		wr_both = 1'b0;
		wr_cur  = 1'b0;
		wr_dest = 1'b0;
		waddr   = {row_q, col_q};
		wdata   = new_value;
		case (state_q)
			S_INIT: begin
				wr_both = 1'b1;
				wdata   = init_value;
			end
			S_IDLE: begin
				wr_cur = accept && (item.mode == MODE_WRITE) && item_inside;
				waddr  = {item_row, item_col};
				wdata  = item.write_temperature;
			end
			S_WB: begin
				wr_dest = 1'b1;
			end
			default: begin
				wr_both = 1'b0;
			end
		endcase
	end

	assign we_a = wr_both || (wr_cur && !cur_q) || (wr_dest && cur_q);
	assign we_b = wr_both || (wr_cur && cur_q) || (wr_dest && !cur_q);

	jhp_grid_ram #(.DATA_W(TEMP_W), .ADDR_W(AW)) u_bank_a (
		.clk    (clk),
		.we     (we_a),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rd0_a),
		.rdata1 (rd1_a)
	);

	jhp_grid_ram #(.DATA_W(TEMP_W), .ADDR_W(AW)) u_bank_b (
		.clk    (clk),
		.we     (we_b),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rd0_b),
		.rdata1 (rd1_b)
	);

	// Reads always come from the current bank
	assign rd0 = cur_q ? rd0_b : rd0_a;
	assign rd1 = cur_q ? rd1_b : rd1_a;

	always_comb begin
		sctrl.border = on_border(row_q, col_q);
		sctrl.last   = cell_last;
		case (state_q)
			S_LR:    sctrl.op = OP_LOAD;
			S_CTR:   sctrl.op = OP_ADD;
			S_WB:    sctrl.op = OP_EVAL;
			default: sctrl.op = OP_HOLD;
		endcase
	end

	jhp_stencil_unit u_stencil (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (sctrl),
		.rdata0       (rd0),
		.rdata1       (rd1),
		.threshold    (threshold_q),
		.new_value    (new_value),
		.sweep_stable (sweep_stable)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			limit_q     <= LIMIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_LIMIT:     limit_q     <= cfg_data[COUNT_W-1:0];
				default:       limit_q     <= limit_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			row_q       <= '0;
			col_q       <= '0;
			cur_q       <= 1'b0;
			stable_q    <= 1'b0;
			mode_q      <= MODE_WRITE;
			inside_q    <= 1'b0;
			done_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// Load a finished result, else drop the one that transfers
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					row_q <= row_nxt;
					col_q <= col_nxt;
					if (cell_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mode_q   <= item.mode;
						inside_q <= item_inside;
						done_q   <= '0;
						row_q    <= '0;
						col_q    <= '0;
						case (item.mode)
							MODE_WRITE: begin
								res_q <= '{read_temperature: '0, is_stable: stable_q,
									sweeps_done: '0};
							end
							MODE_READ: state_q <= S_READ;
							default:   state_q <= S_UD;
						endcase
					end
				end
				S_READ: begin
					res_q   <= '{read_temperature: inside_q ? rd0 : '0,
						is_stable: stable_q, sweeps_done: '0};
					state_q <= S_IDLE;
				end
				S_UD:  state_q <= S_LR;
				S_LR:  state_q <= S_CTR;
				S_CTR: state_q <= S_WB;
				S_WB: begin
					row_q <= row_nxt;
					col_q <= col_nxt;
					if (cell_last) begin
						// Sweep ends: the written bank becomes current
						cur_q    <= !cur_q;
						stable_q <= sweep_stable;
						done_q   <= done_q + COUNT_W'(1);
						if (run_on) begin
							state_q <= S_LR;
						end else begin
							state_q <= S_IDLE;
							res_q   <= '{read_temperature: '0, is_stable: sweep_stable,
								sweeps_done: done_q + COUNT_W'(1)};
						end
					end else begin
						state_q <= S_LR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import jhp_pkg::*;

	localparam int GRID = 32;
	localparam int CELLS = GRID * GRID;
	localparam int SWEEP_CYCLES = 3 * CELLS + 1;
	localparam logic [TEMP_W-1:0] TEMP_MAX = '1;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 70;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_stall;
	item_t plate_request = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predicted plate: current temperatures, the copy a sweep reads from, and the flag
	// left behind by the last sweep.
	logic [TEMP_W-1:0] plate_temp [CELLS];
	logic [TEMP_W-1:0] plate_prev [CELLS];
	logic plate_settled;
	logic [TEMP_W-1:0] thresh_cfg;
	logic [COUNT_W-1:0] limit_cfg;

	item_t plate_requests [$];
	result_t expected_results [$];

	int sender_idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int sweeps_predicted = 0;
	int cycle_count = 0;
	// Grows with every queued item and every predicted sweep; the fill pass comes first.
	int watchdog_limit = 4 * CELLS + 1000;
	bit request_taken = 1'b0;

	int idle_profile [4] = '{0, 62, 0, 20};
	int stall_profile [4] = '{0, 0, 62, 20};

	jacobi_heat_plate_relaxation #(
		.GRID_SIZE(GRID)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(plate_request),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// One Jacobi sweep over the predicted plate. Interior cells take the truncated mean
	// of their four old neighbors; the border stays put. Settled means every signed
	// change stayed strictly below the threshold, so a zero threshold never settles.
	function automatic logic sweep_plate();
		logic settled;
		int idx;
		int delta;
		logic [SUM_W-1:0] sum;
		logic [TEMP_W-1:0] fresh;
		settled = 1'b1;
		plate_prev = plate_temp;
		for (int r = 0; r < GRID; r++) begin
			for (int c = 0; c < GRID; c++) begin
				idx = r * GRID + c;
				fresh = plate_prev[idx];
				if (r != 0 && c != 0 && r != GRID - 1 && c != GRID - 1) begin
					sum = SUM_W'(plate_prev[idx - GRID]) + SUM_W'(plate_prev[idx + GRID])
						+ SUM_W'(plate_prev[idx - 1]) + SUM_W'(plate_prev[idx + 1]);
					fresh = sum[SUM_W-1:2];
					plate_temp[idx] = fresh;
				end
				delta = int'(fresh) - int'(plate_prev[idx]);
				if (delta >= int'(thresh_cfg))
					settled = 1'b0;
			end
		end
		return settled;
	endfunction

	// Apply one transfer to the predicted plate and return the result it must produce.
	function automatic result_t predict_plate(item_t req);
		result_t res;
		int idx;
		int runs;
		int cap;
		res = '0;
		runs = 0;
		idx = int'(req.row) * GRID + int'(req.column);
		case (req.mode)
			MODE_WRITE: begin
				plate_temp[idx] = req.write_temperature;
			end
			MODE_SWEEP: begin
				plate_settled = sweep_plate();
				runs = 1;
			end
			MODE_RUN: begin
				// a zero limit still buys one sweep
				cap = (limit_cfg == '0) ? 1 : int'(limit_cfg);
				do begin
					plate_settled = sweep_plate();
					runs++;
				end while (!plate_settled && runs < cap);
			end
			MODE_READ: begin
				res.read_temperature = plate_temp[idx];
			end
			default: ;
		endcase
		res.is_stable = plate_settled;
		res.sweeps_done = COUNT_W'(runs);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
		input int unsigned want);
		$display("mismatch in %s at result %0d: got %0h, expected %0h",
			field, results_checked, got, want);
		mismatch_count++;
	endtask

	// Sample at the rising edge: register writes, accepted requests, accepted results.
	always @(posedge clk) begin
		result_t want;
		cycle_count++;
		if (cycle_count > watchdog_limit) begin
			$display("tb: failure");
			$finish;
		end else if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					REG_THRESHOLD: thresh_cfg = cfg_data[TEMP_W-1:0];
					REG_LIMIT: limit_cfg = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				want = predict_plate(plate_request);
				expected_results.push_back(want);
				sweeps_predicted += int'(want.sweeps_done);
				// budget the sweeps this transfer sets off, four times over
				watchdog_limit += 4 * SWEEP_CYCLES * int'(want.sweeps_done);
				items_accepted++;
				request_taken = 1'b1;
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", 32'(result.read_temperature), 0);
				end else begin
					want = expected_results.pop_front();
					if (result.read_temperature !== want.read_temperature)
						report_mismatch("read_temperature", 32'(result.read_temperature),
							32'(want.read_temperature));
					if (result.is_stable !== want.is_stable)
						report_mismatch("is_stable", 32'(result.is_stable),
							32'(want.is_stable));
					if (result.sweeps_done !== want.sweeps_done)
						report_mismatch("sweeps_done", 32'(result.sweeps_done),
							32'(want.sweeps_done));
				end
				results_checked++;
			end
		end
	end

	// Request driver: hold the payload until its transfer, then advance or go idle.
	always @(negedge clk) begin
		if (arst_n && (!item_valid || request_taken)) begin
			request_taken = 1'b0;
			if (plate_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				plate_request <= plate_requests.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result side: stall at random per the current profile.
	always @(negedge clk) begin
		result_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	task automatic queue_item(input logic [1:0] mode, input int r, input int c,
		input logic [TEMP_W-1:0] temp);
		item_t req;
		req.mode = mode;
		req.row = COORD_IN_W'(r);
		req.column = COORD_IN_W'(c);
		req.write_temperature = temp;
		plate_requests.push_back(req);
		// gaps and stalls per transfer; sweeps get budgeted on acceptance
		watchdog_limit += 200;
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Drain: every request transferred and every result back, then a short pause.
	task automatic settle();
		while (plate_requests.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Mostly writes and reads spread over the plate, with occasional sweeps.
	task automatic queue_random_item();
		logic [1:0] mode;
		logic [TEMP_W-1:0] temp;
		int r;
		int c;
		int pick;
		pick = $urandom_range(99);
		if (pick < 46)
			mode = MODE_WRITE;
		else if (pick < 90)
			mode = MODE_READ;
		else if (pick < 96)
			mode = MODE_SWEEP;
		else
			mode = MODE_RUN;
		r = $urandom_range(GRID - 1);
		c = $urandom_range(GRID - 1);
		// pull some addresses onto the border
		if ($urandom_range(7) == 0)
			r = $urandom_range(1) ? GRID - 1 : 0;
		if ($urandom_range(7) == 0)
			c = $urandom_range(1) ? GRID - 1 : 0;
		case ($urandom_range(9))
			0: temp = '0;
			1: temp = TEMP_MAX;
			2: temp = HOT_VALUE;
			3, 4, 5: temp = TEMP_W'($urandom);
			default: temp = TEMP_W'($urandom_range(0, 32'h640000));
		endcase
		queue_item(mode, r, c, temp);
	endtask

	initial begin
		logic [TEMP_W-1:0] thresh_pick;
		// Start pattern: hot interior of the top and bottom rows, the rest cold.
		for (int r = 0; r < GRID; r++) begin
			for (int c = 0; c < GRID; c++) begin
				plate_temp[r * GRID + c] = ((r == 0 || r == GRID - 1) && c > 0
					&& c < GRID - 1) ? HOT_VALUE : '0;
			end
		end
		plate_prev = plate_temp;
		plate_settled = 1'b0;
		thresh_cfg = THRESHOLD_RESET;
		limit_cfg = LIMIT_RESET;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Reset contents: corners cold, hot rows hot, interior cold.
		queue_item(MODE_READ, 0, 0, '0);
		queue_item(MODE_READ, 0, 1, '0);
		queue_item(MODE_READ, GRID - 1, GRID - 2, TEMP_MAX);
		queue_item(MODE_READ, GRID - 1, GRID - 1, '0);
		queue_item(MODE_READ, 15, 15, '0);
		queue_item(MODE_SWEEP, 0, 0, '0);
		queue_item(MODE_READ, 1, 1, '0);
		// Extremes of the value, border writes that then stay fixed, flag left alone.
		queue_item(MODE_WRITE, 0, 0, TEMP_MAX);
		queue_item(MODE_WRITE, 0, 10, '0);
		queue_item(MODE_WRITE, 5, 7, TEMP_MAX);
		queue_item(MODE_WRITE, 16, 16, 24'h000001);
		queue_item(MODE_WRITE, GRID - 1, GRID - 1, 24'hAAAAAA);
		queue_item(MODE_READ, 0, 0, '0);
		queue_item(MODE_READ, 5, 7, '0);
		queue_item(MODE_READ, 16, 16, '0);
		queue_item(MODE_READ, GRID - 1, GRID - 1, '0);
		queue_item(MODE_SWEEP, 31, 31, TEMP_MAX);
		queue_item(MODE_READ, 5, 8, '0);
		queue_item(MODE_READ, 0, 10, '0);
		settle();

		// Largest threshold and sweep limit: one sweep settles the run.
		write_register(REG_THRESHOLD, TEMP_MAX);
		write_register(REG_LIMIT, CFG_DATA_W'(LIMIT_RESET));
		queue_item(MODE_RUN, 0, 0, '0);
		queue_item(MODE_READ, 4, 7, '0);
		settle();

		// Zero threshold never settles; a zero limit still runs one sweep.
		write_register(REG_THRESHOLD, '0);
		write_register(REG_LIMIT, '0);
		queue_item(MODE_RUN, 0, 0, '0);
		queue_item(MODE_SWEEP, 0, 0, '0);
		queue_item(MODE_WRITE, 15, 15, TEMP_MAX);
		queue_item(MODE_READ, 15, 15, '0);
		settle();

		// Random phases over every idle/stall profile with a fresh setting each time.
		for (int p = 0; p < PHASES; p++) begin
			sender_idle_pct = idle_profile[p % 4];
			stall_pct = stall_profile[p % 4];
			case ($urandom_range(4))
				0: thresh_pick = '0;
				1: thresh_pick = TEMP_MAX;
				2: thresh_pick = THRESHOLD_RESET;
				3: thresh_pick = TEMP_W'($urandom_range(32'h10000, 32'h200000));
				default: thresh_pick = TEMP_W'($urandom);
			endcase
			write_register(REG_THRESHOLD, thresh_pick);
			// keep run-until-stable short; the largest limit was covered above
			write_register(REG_LIMIT, CFG_DATA_W'($urandom_range(1, 4)));
			repeat (PHASE_ITEMS) queue_random_item();
			settle();
		end

		$display("summary: %0d transfers in, %0d results checked, %0d sweeps predicted",
			items_accepted, results_checked, sweeps_predicted);
		$display("summary: %0d register settings, %0d mismatches, %0d cycles",
			2 * (PHASES + 2), mismatch_count, cycle_count);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
